/* rtl/osd_pkg.sv */
// ----------------------------------------------------------------------------
// OSD command stream decoder package
// Shared result kinds, register indexes and the result record.
// ----------------------------------------------------------------------------
package osd_pkg;

   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned VALUE_W  = 16;
   localparam int unsigned KIND_W   = 2;
   localparam int unsigned CSR_IDX_W = 2;

   // result kinds, carried on rsp_tuser
   localparam logic [KIND_W-1:0] KIND_DATA = 2'd0;
   localparam logic [KIND_W-1:0] KIND_ADDR = 2'd1;
   localparam logic [KIND_W-1:0] KIND_DONE = 2'd2;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_EXT_CODE    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_REPEAT_CODE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_NEXT_CODE   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_END_CODE    = 2'd3;

   localparam logic [BYTE_W-1:0] EXT_CODE_RST    = 8'd252;
   localparam logic [BYTE_W-1:0] REPEAT_CODE_RST = 8'd253;
   localparam logic [BYTE_W-1:0] NEXT_CODE_RST   = 8'd254;
   localparam logic [BYTE_W-1:0] END_CODE_RST    = 8'd255;

   // highest legal extended-character index
   localparam logic [BYTE_W-1:0] MAX_EXT_INDEX = 8'd3;

   // result queue
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [VALUE_W-1:0] value;
      logic [BYTE_W-1:0]  count;
      logic               last;
   } result_type;

endpackage

/* rtl/osd_command_stream_decoder.sv */
// ----------------------------------------------------------------------------
// OSD command stream decoder
// Turns an escape-coded display command stream into data/address port writes.
// ----------------------------------------------------------------------------
// The decoder takes one stream byte per clock while req_tready is high. Each
// accepted request is decoded in the same cycle against the small decode state
// (phase, held address byte, previous byte, pending extended byte) and yields
// zero, one or two results, which are pushed into a four-entry result queue.
// Results leave the queue on the rsp_ side one per cycle while rsp_tready is
// high. req_tready stays high while at most two results are queued, so with a
// listening consumer the sustained rate is one byte per clock; a byte that
// yields two results (an extended byte flushed by the next byte) pushes both
// into the queue at once, and the queue absorbs them. A request with req_tuser
// set restarts the decoder in any phase; its byte is the high byte of the
// start address. The user is to write configuration (escape code values)
// through csr_ only while the block is idle; the block does not enforce this.
module osd_command_stream_decoder (
   input  logic                         clock,
   input  logic                         reset,
   // request channel
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [7:0]                   req_tdata,   // [7:0] stream_byte
   input  logic                         req_tuser,   // [0] first_of_stream
   // result channel
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [23:0]                  rsp_tdata,   // [15:0] write_value,
                                                     // [23:16] write_count
   output logic [osd_pkg::KIND_W-1:0]   rsp_tuser,   // [1:0] write_kind
   output logic                         rsp_tlast,   // last_of_run
   // configuration
   input  logic                         csr_we,
   input  logic [osd_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [7:0]                   csr_wdata
);
   import osd_pkg::*;

   typedef enum logic [3:0] {
      PH_IDLE, PH_ADDR_LO, PH_RUN, PH_EXT_N, PH_EXT_AFTER,
      PH_EXT_COUNT, PH_REP_K, PH_NEXT_HI, PH_NEXT_LO
   } phase_type;

   // escape codes
   logic [BYTE_W-1:0] ext_code_ff, repeat_code_ff, next_code_ff, end_code_ff;

   // decode state
   phase_type         phase_ff, phase_in;
   logic [BYTE_W-1:0] held_hi_ff, held_hi_in;
   logic [BYTE_W-1:0] prev_ff, prev_in;
   logic [BYTE_W-1:0] pend_ff, pend_in;

   // result queue
   result_type        queue_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_W-1:0] count_ff, count_in;

   logic              accept, pop;
   logic [BYTE_W-1:0] b;

   // running-phase decode of the current byte
   phase_type         run_phase;
   logic              run_emit;
   logic              run_prev_wr;
   result_type        run_res;

   // results of this request
   logic              r0_v, r1_v;
   result_type        r0, r1;

   assign accept = req_tvalid && req_tready;
   assign pop    = rsp_tvalid && rsp_tready;
   assign b      = req_tdata;

   // room for two results
   assign req_tready = (count_ff <= QCNT_W'(QUEUE_DEPTH - 2));

   // escape tests in priority order: ext, repeat, next, end
   always_comb begin
      run_phase   = PH_RUN;
      run_emit    = 1'b0;
      run_prev_wr = 1'b1;
      run_res     = '{kind: KIND_DATA, value: VALUE_W'(b), count: 8'd1, last: 1'b0};
      if (b == ext_code_ff) begin
         run_phase = PH_EXT_N;
      end else if (b == repeat_code_ff) begin
         run_phase   = PH_REP_K;
         run_prev_wr = 1'b0;   // the repeat code itself is not recorded
      end else if (b == next_code_ff) begin
         run_phase = PH_NEXT_HI;
      end else if (b == end_code_ff) begin
         run_phase = PH_IDLE;
         run_emit  = 1'b1;
         run_res   = '{kind: KIND_DONE, value: '0, count: '0, last: 1'b0};
      end else begin
         run_emit = 1'b1;
      end
   end

   always_comb begin
      phase_in   = phase_ff;
      held_hi_in = held_hi_ff;
      prev_in    = prev_ff;
      pend_in    = pend_ff;
      r0_v       = 1'b0;
      r1_v       = 1'b0;
      r0         = '{kind: KIND_DATA, value: VALUE_W'(pend_ff), count: 8'd1, last: 1'b0};
      r1         = run_res;
      if (req_tuser) begin
         held_hi_in = b;
         prev_in    = b;
         phase_in   = PH_ADDR_LO;
      end else begin
         case (phase_ff)
            PH_ADDR_LO: begin
               prev_in  = b;
               phase_in = PH_RUN;
               r0_v     = 1'b1;
               r0       = '{kind: KIND_ADDR, value: {held_hi_ff, b}, count: '0, last: 1'b0};
            end
            PH_RUN: begin
               phase_in = run_phase;
               if (run_prev_wr) prev_in = b;
               r0_v = run_emit;
               r0   = run_res;
            end
            PH_EXT_N: begin
               prev_in = b;
               if (b > MAX_EXT_INDEX) begin
                  phase_in = PH_IDLE;
                  r0_v     = 1'b1;
                  r0       = '{kind: KIND_DONE, value: '0, count: '0, last: 1'b0};
               end else begin
                  pend_in  = ext_code_ff + b;   // wraps modulo 256
                  phase_in = PH_EXT_AFTER;
               end
            end
            PH_EXT_AFTER: begin
               if (b == repeat_code_ff) begin
                  prev_in  = b;
                  phase_in = PH_EXT_COUNT;
               end else begin
                  // flush the pending byte once, then decode b as a run byte
                  r0_v     = 1'b1;
                  phase_in = run_phase;
                  if (run_prev_wr) prev_in = b;
                  r1_v = run_emit;
               end
            end
            PH_EXT_COUNT: begin
               prev_in  = b;
               phase_in = PH_RUN;
               r0_v     = (b != '0);
               r0.count = b;
            end
            PH_REP_K: begin
               phase_in = PH_RUN;
               r0_v     = (b > 8'd1);
               r0       = '{kind: KIND_DATA, value: VALUE_W'(prev_ff),
                            count: b - 8'd1, last: 1'b0};
               prev_in  = b;
            end
            PH_NEXT_HI: begin
               held_hi_in = b;
               prev_in    = b;
               phase_in   = PH_NEXT_LO;
            end
            PH_NEXT_LO: begin
               prev_in = b;
               r0_v    = 1'b1;
               if (b == end_code_ff) begin
                  phase_in = PH_IDLE;
                  r0       = '{kind: KIND_DONE, value: '0, count: '0, last: 1'b0};
               end else begin
                  phase_in = PH_RUN;
                  r0       = '{kind: KIND_ADDR, value: {held_hi_ff, b}, count: '0, last: 1'b0};
               end
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase
      end
      r0.last = !r1_v;
      r1.last = 1'b1;
   end

   always_comb begin
      count_in = count_ff;
      if (accept) count_in = count_in + QCNT_W'(r0_v) + QCNT_W'(r1_v);
      if (pop)    count_in = count_in - QCNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ext_code_ff    <= EXT_CODE_RST;
         repeat_code_ff <= REPEAT_CODE_RST;
         next_code_ff   <= NEXT_CODE_RST;
         end_code_ff    <= END_CODE_RST;
         phase_ff       <= PH_IDLE;
         held_hi_ff     <= '0;
         prev_ff        <= '0;
         pend_ff        <= '0;
         wr_ptr_ff      <= '0;
         rd_ptr_ff      <= '0;
         count_ff       <= '0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_EXT_CODE:    ext_code_ff    <= csr_wdata;
               CSR_REPEAT_CODE: repeat_code_ff <= csr_wdata;
               CSR_NEXT_CODE:   next_code_ff   <= csr_wdata;
               CSR_END_CODE:    end_code_ff    <= csr_wdata;
               default:         ;
            endcase
         end
         if (accept) begin
            phase_ff   <= phase_in;
            held_hi_ff <= held_hi_in;
            prev_ff    <= prev_in;
            pend_ff    <= pend_in;
            wr_ptr_ff  <= wr_ptr_ff + QPTR_W'(r0_v) + QPTR_W'(r1_v);
         end
         if (pop) rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
         count_ff <= count_in;
      end
   end

   // queue payload, no reset
   always_ff @(posedge clock) begin
      if (accept && r0_v) queue_ff[wr_ptr_ff] <= r0;
      if (accept && r1_v) queue_ff[wr_ptr_ff + QPTR_W'(1)] <= r1;
   end

   assign rsp_tvalid = (count_ff != '0);
   assign rsp_tdata  = {queue_ff[rd_ptr_ff].count, queue_ff[rd_ptr_ff].value};
   assign rsp_tuser  = queue_ff[rd_ptr_ff].kind;
   assign rsp_tlast  = queue_ff[rd_ptr_ff].last;

endmodule

/* rtl/osd_checker.sv */
// ----------------------------------------------------------------------------
// OSD command stream decoder port checker
// Port-level assertions, bound to the decoder top level.
// ----------------------------------------------------------------------------
module osd_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_tvalid,
   input logic                          rsp_tready,
   input logic [23:0]                   rsp_tdata,
   input logic [osd_pkg::KIND_W-1:0]    rsp_tuser,
   input logic                          rsp_tlast
);
   import osd_pkg::*;

   // nothing pending right after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid right after reset");

   // held result keeps its payload
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled result changed");

   // data writes always carry a nonzero count and an upper value byte of zero
   a_data_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == KIND_DATA |-> rsp_tdata[23:16] != 8'd0
         && rsp_tdata[15:8] == 8'd0)
      else $error("bad data write");

   // stream finished: empty payload, ends the run of its request
   a_done_payload: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == KIND_DONE |-> rsp_tdata == 24'd0 && rsp_tlast)
      else $error("bad stream-finished result");

   // address writes carry no count and end the run of their request
   a_addr_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == KIND_ADDR |-> rsp_tdata[23:16] == 8'd0 && rsp_tlast)
      else $error("bad address write");

endmodule

bind osd_command_stream_decoder osd_checker u_osd_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
